@@ rtl/core/imubc_pkg.sv @@
package imubc_pkg;

    // Field widths
    localparam int RAW_W   = 16;
    localparam int VAL_W   = 29;
    localparam int SCALE_W = 12;
    localparam int NUM_AXES = 6;
    localparam int NUM_GYRO = 3;

    // Configuration port
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int RSEL_W  = 2;
    localparam logic REG_ACCEL_RANGE = 1'b0;
    localparam logic REG_GYRO_RANGE  = 1'b1;

    // Command and result codes
    localparam logic CMD_CALIBRATE = 1'b0;
    localparam logic CMD_CONVERT   = 1'b1;
    localparam logic KIND_CONVERT  = 1'b0;
    localparam logic KIND_BIAS     = 1'b1;

    typedef logic signed [RAW_W-1:0]   t_raw;
    typedef logic signed [VAL_W-1:0]   t_val;
    typedef logic        [SCALE_W-1:0] t_scale;
    typedef logic        [RSEL_W-1:0]  t_rsel;

    // Gravity removal, Q13.16
    localparam t_val GRAVITY   = t_val'(65536);
    localparam t_val GRAV_THRESH = t_val'(52429);

    // Full scale times two, indexed by the range select code
    localparam t_scale ACCEL_SCALE [4] = '{t_scale'(4), t_scale'(32), t_scale'(8),
                                           t_scale'(16)};
    localparam t_scale GYRO_SCALE [4]  = '{t_scale'(490), t_scale'(1000),
                                           t_scale'(2000), t_scale'(4000)};

    // Per-lane control from the issue logic
    typedef struct packed {
        logic acc;      // calibration beat accepted: add into the sum
        logic clr;      // that beat completes calibration: clear the sum
        logic load;     // beat enters the product stage
        logic start;    // launch the bias division
        logic fin;      // product stage holds a finished calibration
        logic bias_we;  // commit the new bias
    } t_lane_ctrl;

endpackage

@@ rtl/core/imubc_in_if.sv @@
interface imubc_in_if;
    import imubc_pkg::*;

    logic valid;
    logic ready;
    logic cmd;
    t_raw gyro_x_raw;
    t_raw gyro_y_raw;
    t_raw gyro_z_raw;
    t_raw accel_x_raw;
    t_raw accel_y_raw;
    t_raw accel_z_raw;

    modport source (
        output valid, cmd, gyro_x_raw, gyro_y_raw, gyro_z_raw,
               accel_x_raw, accel_y_raw, accel_z_raw,
        input  ready
    );
    modport sink (
        input  valid, cmd, gyro_x_raw, gyro_y_raw, gyro_z_raw,
               accel_x_raw, accel_y_raw, accel_z_raw,
        output ready
    );
endinterface

@@ rtl/core/imubc_out_if.sv @@
interface imubc_out_if;
    import imubc_pkg::*;

    logic valid;
    logic ready;
    logic result_kind;
    t_val gyro_x_value;
    t_val gyro_y_value;
    t_val gyro_z_value;
    t_val accel_x_value;
    t_val accel_y_value;
    t_val accel_z_value;

    modport source (
        output valid, result_kind, gyro_x_value, gyro_y_value, gyro_z_value,
               accel_x_value, accel_y_value, accel_z_value,
        input  ready
    );
    modport sink (
        input  valid, result_kind, gyro_x_value, gyro_y_value, gyro_z_value,
               accel_x_value, accel_y_value, accel_z_value,
        output ready
    );
endinterface

@@ rtl/core/imubc_lane.sv @@
module imubc_lane #(
    parameter int CAL_SAMPLES = 128,
    parameter bit IS_ACCEL    = 1'b0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  imubc_pkg::t_lane_ctrl  i_ctrl,
    input  imubc_pkg::t_raw        i_raw,
    input  imubc_pkg::t_scale      i_scale,
    output imubc_pkg::t_val        o_value,
    output logic                   o_done
);
    import imubc_pkg::*;

    localparam int LOG2_C  = $clog2(CAL_SAMPLES);
    localparam int SUM_W   = RAW_W + LOG2_C;
    localparam int PROD_W  = SUM_W + SCALE_W + 1;
    localparam bit IS_POW2 = (CAL_SAMPLES & (CAL_SAMPLES - 1)) == 0;

    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  w_mul_a;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    t_val                     r_bias;
    t_val                     w_quo;
    t_val                     w_adj;

    // Running sum and multiplier operand
    assign n_sum   = r_sum + SUM_W'(i_raw);
    assign w_mul_a = i_ctrl.clr ? n_sum : SUM_W'(i_raw);
    assign n_prod  = PROD_W'(w_mul_a) * $signed(PROD_W'({1'b0, i_scale}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.acc) begin
            r_sum <= i_ctrl.clr ? '0 : n_sum;
        end
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_prod <= n_prod;
        end
    end

    // Floor division of the scaled sum by the sample count
    generate
        if (IS_POW2) begin : g_shift
            assign w_quo  = t_val'(r_prod >>> LOG2_C);
            assign o_done = 1'b1;
        end else begin : g_divider
            // floor(sum * scale / N) = q * scale + floor(rem * scale / N),
            // with q and rem from the sum; each quotient by reciprocal multiply
            localparam int X2_W = LOG2_C + SCALE_W;
            localparam int P1_W = 2 * SUM_W + 1;
            localparam int P2_W = 2 * X2_W + 1;
            localparam int SH1  = SUM_W + LOG2_C;
            localparam int SH2  = X2_W + LOG2_C;
            localparam logic [SUM_W:0] M1 =
                (SUM_W + 1)'((longint'(1) << SH1) / CAL_SAMPLES + 1);
            localparam logic [X2_W:0] M2 =
                (X2_W + 1)'((longint'(1) << SH2) / CAL_SAMPLES + 1);
            localparam logic [SUM_W-1:0] OFFSET = SUM_W'(CAL_SAMPLES << (RAW_W - 1));

            logic [SUM_W-1:0]   r_u;
            t_scale             r_cscale;
            logic [P1_W-1:0]    w_p1;
            logic [RAW_W-1:0]   r_q1;
            logic [LOG2_C-1:0]  r_rem;
            t_raw               r_qn;
            logic [X2_W-1:0]    r_x2;
            t_val               r_qs;
            logic [P2_W-1:0]    w_p2;
            logic [SCALE_W-1:0] r_q2;
            t_val               r_res;
            logic [3:0]         r_pipe_v;
            logic               r_done;

            // Capture the sum, offset to be non-negative, and the scale in force
            always_ff @(posedge i_clk) begin
                if (i_ctrl.clr) begin
                    r_u      <= $unsigned(n_sum) + OFFSET;
                    r_cscale <= i_scale;
                end
            end

            assign w_p1 = P1_W'(r_u) * P1_W'(M1);
            assign w_p2 = P2_W'(r_x2) * P2_W'(M2);

            // Five register stages; operands hold still until the next capture
            always_ff @(posedge i_clk) begin
                r_q1  <= w_p1[SH1 +: RAW_W];
                r_rem <= LOG2_C'(r_u - SUM_W'(r_q1) * SUM_W'(CAL_SAMPLES));
                r_qn  <= t_raw'({~r_q1[RAW_W-1], r_q1[RAW_W-2:0]});
                r_x2  <= X2_W'(r_rem) * X2_W'(r_cscale);
                r_qs  <= t_val'(r_qn) * $signed(t_val'({1'b0, r_cscale}));
                r_q2  <= w_p2[SH2 +: SCALE_W];
                r_res <= r_qs + t_val'(r_q2);
            end

            // Track the launch through the stages
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pipe_v <= '0;
                    r_done   <= 1'b0;
                end else begin
                    r_pipe_v <= {r_pipe_v[2:0], i_ctrl.start};
                    if (i_ctrl.start) begin
                        r_done <= 1'b0;
                    end else if (r_pipe_v[3]) begin
                        r_done <= 1'b1;
                    end else if (i_ctrl.bias_we) begin
                        r_done <= 1'b0;
                    end
                end
            end

            assign w_quo  = r_res;
            assign o_done = r_done;
        end
    endgenerate

    // Drop gravity from an accelerometer bias
    always_comb begin
        w_adj = w_quo;
        if (IS_ACCEL) begin
            if (w_quo > GRAV_THRESH) begin
                w_adj = w_quo - GRAVITY;
            end else if (w_quo < -GRAV_THRESH) begin
                w_adj = w_quo + GRAVITY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
        end else if (i_ctrl.bias_we) begin
            r_bias <= w_adj;
        end
    end

    // Converted value, or the new bias at the end of calibration
    assign o_value = i_ctrl.fin ? w_adj : (t_val'(r_prod) - r_bias);

endmodule

@@ rtl/core/imubc_merge.sv @@
module imubc_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_kind,
    input  imubc_pkg::t_val      i_values [imubc_pkg::NUM_AXES],
    output logic                 o_free,
    imubc_out_if.source          o_out
);
    import imubc_pkg::*;

    logic r_valid;
    logic r_kind;
    t_val r_val [NUM_AXES];

    assign o_free = !r_valid || o_out.ready;

    // Output register: hold until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind <= i_kind;
            r_val  <= i_values;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.result_kind   = r_kind;
    assign o_out.gyro_x_value  = r_val[0];
    assign o_out.gyro_y_value  = r_val[1];
    assign o_out.gyro_z_value  = r_val[2];
    assign o_out.accel_x_value = r_val[3];
    assign o_out.accel_y_value = r_val[4];
    assign o_out.accel_z_value = r_val[5];

endmodule

@@ rtl/core/imu_bias_calibration_and_scaling.sv @@
// Convert beats: one accepted per cycle while the output is not stalled and no bias division
// is pending; each result is registered in the product stage, then in the output register.
// Completing calibration beat: same path when CAL_SAMPLES is a power of two, else a
// five-stage reciprocal divider per lane lies in between while further input is held.
// Reset (synchronous, i_rst_n low) clears range selects, sums, sample count, biases
// and the output valid.
module imu_bias_calibration_and_scaling #(
    parameter int CAL_SAMPLES = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    imubc_in_if.sink                      i_in,
    imubc_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [imubc_pkg::ADDR_W-1:0]  paddr,
    input  logic [imubc_pkg::DATA_W-1:0]  pwdata,
    output logic [imubc_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import imubc_pkg::*;

    localparam int CNT_W = $clog2(CAL_SAMPLES);

    t_rsel             r_accel_rsel;
    t_rsel             r_gyro_rsel;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_s1_valid;
    logic              r_s1_fin;
    logic              r_start;
    logic              w_accept;
    logic              w_cal;
    logic              w_last;
    logic              w_s1_adv;
    logic              w_free;
    logic              w_cfg_we;
    logic [NUM_AXES-1:0] w_done;
    t_lane_ctrl        w_ctrl;
    t_raw              w_raw [NUM_AXES];
    t_val              w_value [NUM_AXES];

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_rsel <= '0;
            r_gyro_rsel  <= '0;
        end else if (w_cfg_we) begin
            if (paddr[2] == REG_ACCEL_RANGE) begin
                r_accel_rsel <= pwdata[RSEL_W-1:0];
            end else begin
                r_gyro_rsel <= pwdata[RSEL_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ACCEL_RANGE) ? DATA_W'(r_accel_rsel)
                                                  : DATA_W'(r_gyro_rsel);

    // Issue: accept a beat when the product stage is empty or moving on
    assign w_accept = i_in.valid && i_in.ready;
    assign w_cal    = i_in.cmd == CMD_CALIBRATE;
    assign w_last   = r_cnt == CNT_W'(CAL_SAMPLES - 1);
    assign w_s1_adv = r_s1_valid && (!r_s1_fin || (&w_done)) && w_free;
    assign i_in.ready = !r_s1_valid || w_s1_adv;

    always_comb begin
        w_ctrl.acc     = w_accept && w_cal;
        w_ctrl.clr     = w_accept && w_cal && w_last;
        w_ctrl.load    = w_accept && (!w_cal || w_last);
        w_ctrl.start   = r_start;
        w_ctrl.fin     = r_s1_fin;
        w_ctrl.bias_we = w_s1_adv && r_s1_fin;
    end

    // Calibration sample count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_ctrl.acc) begin
            r_cnt <= w_last ? '0 : r_cnt + 1'b1;
        end
    end

    // Product stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fin   <= 1'b0;
            r_start    <= 1'b0;
        end else begin
            r_start <= w_ctrl.clr;
            if (w_ctrl.load) begin
                r_s1_valid <= 1'b1;
                r_s1_fin   <= w_ctrl.clr;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
                r_s1_fin   <= 1'b0;
            end
        end
    end

    assign w_raw[0] = i_in.gyro_x_raw;
    assign w_raw[1] = i_in.gyro_y_raw;
    assign w_raw[2] = i_in.gyro_z_raw;
    assign w_raw[3] = i_in.accel_x_raw;
    assign w_raw[4] = i_in.accel_y_raw;
    assign w_raw[5] = i_in.accel_z_raw;

    // One lane per axis
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        imubc_lane #(
            .CAL_SAMPLES (CAL_SAMPLES),
            .IS_ACCEL    (g >= NUM_GYRO)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_raw   (w_raw[g]),
            .i_scale ((g < NUM_GYRO) ? GYRO_SCALE[r_gyro_rsel] : ACCEL_SCALE[r_accel_rsel]),
            .o_value (w_value[g]),
            .o_done  (w_done[g])
        );
    end

    // Merge the lanes into the output beat
    imubc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_s1_adv),
        .i_kind   (r_s1_fin ? KIND_BIAS : KIND_CONVERT),
        .i_values (w_value),
        .o_free   (w_free),
        .o_out    (o_out)
    );

endmodule

@@ tb/imubc_checker.sv @@
module imubc_checker #(
    parameter int CAL_N = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    imubc_in_if                          i_in,
    imubc_out_if                         i_out,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [imubc_pkg::ADDR_W-1:0] i_paddr,
    input  logic [imubc_pkg::DATA_W-1:0] i_pwdata,
    input  logic [imubc_pkg::DATA_W-1:0] i_prdata,
    input  logic                         i_pready,
    output int                           o_fail_count,
    output int                           o_pending
);
    import imubc_pkg::*;

    localparam int     MAX_PRINTED = 40;
    localparam longint GYRO_FS  [4] = '{245, 500, 1000, 2000};
    localparam longint ACCEL_FS [4] = '{2, 16, 4, 8};

    // One output beat: kind plus six axis values, gyro x at index 0
    typedef struct packed {
        logic                kind;
        t_val [NUM_AXES-1:0] value;
    } t_imu_reading;

    t_imu_reading readings_due [$];

    // Own copy of the block state
    t_rsel  accel_sel;
    t_rsel  gyro_sel;
    longint axis_sum  [NUM_AXES];
    longint axis_bias [NUM_AXES];
    int     cal_taken;

    string axis_name [NUM_AXES] = '{"gyro_x", "gyro_y", "gyro_z",
                                    "accel_x", "accel_y", "accel_z"};

    wire [ADDR_W-3:0] reg_index = i_paddr[ADDR_W-1:2];

    task automatic report_mismatch(input string what);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTED)
            $display("%0t mismatch: %s", $time, what);
    endtask

    // Q13.16 units per raw count on the given axis at the ranges now in force
    function automatic longint axis_gain(input int axis);
        if (axis < NUM_GYRO) return 2 * GYRO_FS[gyro_sel];
        return 2 * ACCEL_FS[accel_sel];
    endfunction

    // Accumulate or convert one accepted sample, queue what it yields
    task automatic predict_sample(input logic cmd, input t_raw [NUM_AXES-1:0] raw);
        t_imu_reading r;
        longint       b;
        longint       prod;
        if (cmd == CMD_CALIBRATE) begin
            for (int a = 0; a < NUM_AXES; a++) axis_sum[a] += longint'(signed'(raw[a]));
            cal_taken++;
            if (cal_taken < CAL_N) return;
            r.kind = KIND_BIAS;
            for (int a = 0; a < NUM_AXES; a++) begin
                // floor division, scale taken at completion
                prod = axis_sum[a] * axis_gain(a);
                b = prod / CAL_N;
                if ((prod % CAL_N) != 0 && prod < 0) b -= 1;
                // strip gravity from the accelerometer axes
                if (a >= NUM_GYRO) begin
                    if (b > longint'(GRAV_THRESH)) b -= longint'(GRAVITY);
                    else if (b < -longint'(GRAV_THRESH)) b += longint'(GRAVITY);
                end
                axis_bias[a] = b;
                axis_sum[a] = 0;
                r.value[a] = t_val'(b);
            end
            cal_taken = 0;
        end else begin
            r.kind = KIND_CONVERT;
            for (int a = 0; a < NUM_AXES; a++)
                r.value[a] = t_val'(longint'(signed'(raw[a])) * axis_gain(a) - axis_bias[a]);
        end
        readings_due.push_back(r);
    endtask

    // Compare one output beat with the oldest expectation
    task automatic check_reading(input t_imu_reading seen);
        t_imu_reading want;
        if (readings_due.size() == 0) begin
            report_mismatch($sformatf("output beat with nothing expected, kind %0d", seen.kind));
            return;
        end
        want = readings_due.pop_front();
        if (seen.kind !== want.kind)
            report_mismatch($sformatf("result_kind: got %0d, want %0d", seen.kind, want.kind));
        for (int a = 0; a < NUM_AXES; a++)
            if (seen.value[a] !== want.value[a])
                report_mismatch($sformatf("%s: got %0d, want %0d", axis_name[a],
                                          signed'(seen.value[a]), signed'(want.value[a])));
    endtask

    always @(posedge i_clk) begin : watch
        t_imu_reading        seen;
        t_raw [NUM_AXES-1:0] raw;
        t_rsel               held;
        if (!i_rst_n) begin
            readings_due.delete();
            accel_sel = '0;
            gyro_sel = '0;
            cal_taken = 0;
            o_fail_count = 0;
            for (int a = 0; a < NUM_AXES; a++) begin
                axis_sum[a] = 0;
                axis_bias[a] = 0;
            end
            o_pending <= 0;
        end else begin
            // register writes, and read-back of the selects
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (reg_index == REG_ACCEL_RANGE) accel_sel = t_rsel'(i_pwdata);
                    else if (reg_index == REG_GYRO_RANGE) gyro_sel = t_rsel'(i_pwdata);
                end else begin
                    held = (reg_index == REG_ACCEL_RANGE) ? accel_sel : gyro_sel;
                    if (i_prdata !== DATA_W'(held))
                        report_mismatch($sformatf("register %0d read %0h, want %0h",
                                                  reg_index, i_prdata, held));
                end
            end
            // input beats
            if (i_in.valid && i_in.ready) begin
                raw = {i_in.accel_z_raw, i_in.accel_y_raw, i_in.accel_x_raw,
                       i_in.gyro_z_raw, i_in.gyro_y_raw, i_in.gyro_x_raw};
                predict_sample(i_in.cmd, raw);
            end
            // output beats
            if (i_out.valid && i_out.ready) begin
                seen.kind = i_out.result_kind;
                seen.value = {i_out.accel_z_value, i_out.accel_y_value, i_out.accel_x_value,
                              i_out.gyro_z_value, i_out.gyro_y_value, i_out.gyro_x_value};
                check_reading(seen);
            end
            o_pending <= readings_due.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    import imubc_pkg::*;

    localparam int CAL_N       = 128;
    localparam int PERIOD      = 20;
    localparam int RST_CYCLES  = 12;
    localparam int DRAIN       = 16;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 190;
    localparam int LONG_HOLD   = 300;
    localparam int LIMIT       = 200000;

    // How each axis of a calibration set is shaped
    typedef enum int {
        SHAPE_NOISE, SHAPE_RAIL, SHAPE_PLUS_G, SHAPE_MINUS_G, SHAPE_KNEE, SHAPE_DRIFT
    } t_axis_shape;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   tx_idle_pct = 7;
    int   rx_idle_pct = 81;
    logic rx_ready = 1'b0;
    logic start_long_hold = 1'b0;
    logic hold_taken = 1'b0;
    int   rx_hold_left = 0;

    t_rsel       accel_sel_now;
    int          cal_sent;
    t_axis_shape set_shape [NUM_AXES];
    int          set_base  [NUM_AXES];
    int          set_noise [NUM_AXES];

    imubc_in_if  sample_bus ();
    imubc_out_if reading_bus ();

    assign reading_bus.ready = rx_ready;

    imu_bias_calibration_and_scaling #(
        .CAL_SAMPLES(CAL_N)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_bus),
        .o_out   (reading_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    imubc_checker #(
        .CAL_N(CAL_N)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (sample_bus),
        .i_out        (reading_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(PERIOD / 2) i_clk = ~i_clk;
    end

    // Receiver: one long hold-off on request, otherwise random stalls
    always @(posedge i_clk) begin
        if (start_long_hold && !hold_taken) begin
            hold_taken <= 1'b1;
            rx_hold_left <= LONG_HOLD;
            rx_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            rx_ready <= 1'b0;
        end else begin
            rx_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("** imu_bias_calibration_and_scaling: FAILED **");
            $finish;
        end
    end

    // Offer one sample after a random gap and hold it until accepted
    task automatic send_sample(input logic cmd, input t_raw [NUM_AXES-1:0] raw);
        while ($urandom_range(99) < tx_idle_pct) begin
            sample_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_bus.valid <= 1'b1;
        sample_bus.cmd <= cmd;
        sample_bus.gyro_x_raw <= raw[0];
        sample_bus.gyro_y_raw <= raw[1];
        sample_bus.gyro_z_raw <= raw[2];
        sample_bus.accel_x_raw <= raw[3];
        sample_bus.accel_y_raw <= raw[4];
        sample_bus.accel_z_raw <= raw[5];
        do @(posedge i_clk); while (!sample_bus.ready);
    endtask

    // Drop valid and let every expected beat arrive
    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // One register access: setup cycle, access cycle, then back to idle
    task automatic apb_access(input logic wr, input logic idx, input t_rsel sel);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= ($urandom & 32'hFFFF_FFFC) | DATA_W'(sel);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_ranges(input t_rsel accel_sel, input t_rsel gyro_sel);
        apb_access(1'b1, REG_ACCEL_RANGE, accel_sel);
        apb_access(1'b1, REG_GYRO_RANGE, gyro_sel);
        apb_access(1'b0, REG_ACCEL_RANGE, '0);
        apb_access(1'b0, REG_GYRO_RANGE, '0);
        accel_sel_now = accel_sel;
    endtask

    // Pick a fresh shape per axis for the next calibration set
    task automatic start_cal_set();
        int g;
        int span;
        g = int'(ACCEL_SCALE[accel_sel_now]);
        for (int a = 0; a < NUM_AXES; a++) begin
            set_shape[a] = t_axis_shape'($urandom_range(5));
            set_base[a] = 0;
            set_noise[a] = 0;
            case (set_shape[a])
                SHAPE_NOISE: ;
                SHAPE_RAIL: set_base[a] = $urandom_range(1) ? 32767 : -32768;
                SHAPE_PLUS_G: begin
                    set_base[a] = 65536 / g;
                    set_noise[a] = 40;
                end
                SHAPE_MINUS_G: begin
                    set_base[a] = -(65536 / g);
                    set_noise[a] = 40;
                end
                SHAPE_KNEE: begin
                    // target sum that puts the bias a step or two either side of 0.8 g
                    span = 256 / g + 1;
                    set_base[a] = (int'(GRAV_THRESH) * CAL_N) / g
                                  + int'($urandom_range(2 * span)) - span;
                    if ($urandom_range(1)) set_base[a] = -set_base[a];
                end
                default: begin
                    set_base[a] = int'($urandom_range(600)) - 300;
                    set_noise[a] = 20;
                end
            endcase
        end
    endtask

    // Next calibration count on one axis of the current set
    function automatic t_raw shaped_count(input int a);
        int v;
        int mag;
        case (set_shape[a])
            SHAPE_NOISE: return t_raw'($urandom);
            SHAPE_KNEE: begin
                // spread the target sum evenly over the set
                mag = (set_base[a] < 0) ? -set_base[a] : set_base[a];
                v = mag / CAL_N + ((cal_sent < mag % CAL_N) ? 1 : 0);
                return t_raw'((set_base[a] < 0) ? -v : v);
            end
            default: begin
                v = set_base[a] + int'($urandom_range(2 * set_noise[a])) - set_noise[a];
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return t_raw'(v);
            end
        endcase
    endfunction

    // Convert count: mostly random, with the rails now and then
    function automatic t_raw loose_count();
        case ($urandom_range(7))
            0: return t_raw'(16'h7FFF);
            1: return t_raw'(16'h8000);
            default: return t_raw'($urandom);
        endcase
    endfunction

    initial begin
        t_raw [NUM_AXES-1:0] raw;
        t_rsel               accel_pick;
        t_rsel               gyro_pick;
        sample_bus.valid <= 1'b0;
        sample_bus.cmd <= CMD_CALIBRATE;
        sample_bus.gyro_x_raw <= '0;
        sample_bus.gyro_y_raw <= '0;
        sample_bus.gyro_z_raw <= '0;
        sample_bus.accel_x_raw <= '0;
        sample_bus.accel_y_raw <= '0;
        sample_bus.accel_z_raw <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_rst_n <= 1'b0;
        cal_sent = 0;
        accel_sel_now = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: rails and bit patterns at the lowest and highest range codes
        for (int r = 0; r < 2; r++) begin
            set_ranges(r ? 2'd3 : 2'd0, r ? 2'd3 : 2'd0);
            if (r == 0) start_long_hold <= 1'b1;
            for (int k = 0; k < 8; k++) begin
                for (int a = 0; a < NUM_AXES; a++)
                    case (k)
                        0: raw[a] = 16'h7FFF;
                        1: raw[a] = 16'h8000;
                        2: raw[a] = 16'h0000;
                        3: raw[a] = 16'hFFFF;
                        4: raw[a] = 16'h0001;
                        5: raw[a] = a[0] ? 16'hAAAA : 16'h5555;
                        6: raw[a] = a[0] ? 16'h5555 : 16'hAAAA;
                        default: raw[a] = a[0] ? 16'h8000 : 16'h7FFF;
                    endcase
                send_sample(CMD_CONVERT, raw);
            end
            wait_drained();
        end

        // Random: calibration sets with converts mixed in, ranges changed between phases
        start_cal_set();
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p / 2)
                0: begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 81;
                end
                1: begin
                    tx_idle_pct = 81;
                    rx_idle_pct = 7;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (p)
                0: begin accel_pick = 2'd3; gyro_pick = 2'd3; end
                1: begin accel_pick = 2'd1; gyro_pick = 2'd0; end
                2: begin accel_pick = 2'd2; gyro_pick = 2'd1; end
                3: begin accel_pick = 2'd0; gyro_pick = 2'd2; end
                default: begin
                    accel_pick = t_rsel'($urandom_range(3));
                    gyro_pick = t_rsel'($urandom_range(3));
                end
            endcase
            set_ranges(accel_pick, gyro_pick);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 70) begin
                    for (int a = 0; a < NUM_AXES; a++) raw[a] = shaped_count(a);
                    send_sample(CMD_CALIBRATE, raw);
                    cal_sent++;
                    if (cal_sent == CAL_N) begin
                        cal_sent = 0;
                        start_cal_set();
                    end
                end else begin
                    for (int a = 0; a < NUM_AXES; a++) raw[a] = loose_count();
                    send_sample(CMD_CONVERT, raw);
                end
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("** imu_bias_calibration_and_scaling: PASSED **");
        end else begin
            $display("** imu_bias_calibration_and_scaling: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/imubc_pkg.sv
rtl/core/imubc_in_if.sv
rtl/core/imubc_out_if.sv
rtl/core/imubc_lane.sv
rtl/core/imubc_merge.sv
rtl/core/imu_bias_calibration_and_scaling.sv
tb/imubc_checker.sv
tb/testbench.sv
